// ----- rtl/wlf_pkg.sv -----
// Shared types and constants of the weighted line-fit accumulator.
// Used by wlf_unit and weighted_line_fit_accumulator; no dependencies.
package wlf_pkg;

  localparam int MaxPoints = 1024;
  localparam int CountW    = 11;
  localparam int DataW     = 128;
  localparam int StepW     = $clog2(DataW);

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_REM   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_QUERY = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_FULL   = 2'd1,
    STS_EMPTY  = 2'd2,
    STS_DEGEN  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    UOP_MUL  = 2'd0,
    UOP_DIV  = 2'd1,
    UOP_SQRT = 2'd2
  } unit_op_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_req_t;

endpackage

// ----- rtl/wlf_unit.sv -----
// Shared iterative arithmetic unit: shift-add multiply, restoring divide,
// digit-by-digit square root. Depends on wlf_pkg.
module wlf_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  wlf_pkg::unit_req_t        req_i,
  input  logic [wlf_pkg::DataW-1:0] a_i,
  input  logic [wlf_pkg::DataW-1:0] b_i,
  output logic                      done_o,
  output logic [wlf_pkg::DataW-1:0] res_o
);

  localparam int W = wlf_pkg::DataW;

  wlf_pkg::unit_op_e           op_q;
  logic                        busy_q;
  logic                        done_q;
  logic                        neg_q;
  logic [wlf_pkg::StepW-1:0]   cnt_q;
  logic [W-1:0]                acc_q, ra_q, rb_q, qt_q, res_q;

  logic [W-1:0] a_mag, b_mag, mul_sum, mul_res;
  logic [W-1:0] div_rem, div_rem_n, div_q_n;
  logic [W-1:0] sq_t, sq_root_n;
  logic         div_ge, sq_ge;

  // signed magnitudes for the multiplier
  assign a_mag   = a_i[W-1] ? (~a_i + W'(1)) : a_i;
  assign b_mag   = b_i[W-1] ? (~b_i + W'(1)) : b_i;
  assign mul_sum = acc_q + (rb_q[0] ? ra_q : '0);
  assign mul_res = neg_q ? (~acc_q + W'(1)) : acc_q;

  assign div_rem   = {acc_q[W-2:0], ra_q[W-1]};
  assign div_ge    = div_rem >= rb_q;
  assign div_rem_n = div_ge ? (div_rem - rb_q) : div_rem;
  assign div_q_n   = {qt_q[W-2:0], div_ge};

  assign sq_t      = qt_q + ra_q;
  assign sq_ge     = acc_q >= sq_t;
  assign sq_root_n = sq_ge ? ((qt_q >> 1) + ra_q) : (qt_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= wlf_pkg::UOP_MUL;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      acc_q  <= '0;
      ra_q   <= '0;
      rb_q   <= '0;
      qt_q   <= '0;
      res_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        op_q   <= req_i.op;
        busy_q <= 1'b1;
        qt_q   <= '0;
        case (req_i.op)
          wlf_pkg::UOP_MUL: begin
            acc_q <= '0;
            ra_q  <= a_mag;
            rb_q  <= b_mag;
            neg_q <= a_i[W-1] ^ b_i[W-1];
          end
          wlf_pkg::UOP_DIV: begin
            acc_q <= '0;
            ra_q  <= a_i;
            rb_q  <= b_i;
            cnt_q <= wlf_pkg::StepW'(W - 1);
          end
          wlf_pkg::UOP_SQRT: begin
            acc_q <= {{(W/2){1'b0}}, a_i[W/2-1:0]};
            ra_q  <= W'(1) << (W/2 - 2);
            cnt_q <= wlf_pkg::StepW'(W/4 - 1);
          end
          default: begin
            busy_q <= 1'b0;
          end
        endcase
      end else if (busy_q) begin
        case (op_q)
          wlf_pkg::UOP_MUL: begin
            if (rb_q == '0) begin
              res_q  <= mul_res;
              done_q <= 1'b1;
              busy_q <= 1'b0;
            end else begin
              acc_q <= mul_sum;
              ra_q  <= ra_q << 1;
              rb_q  <= rb_q >> 1;
            end
          end
          wlf_pkg::UOP_DIV: begin
            acc_q <= div_rem_n;
            qt_q  <= div_q_n;
            ra_q  <= ra_q << 1;
            cnt_q <= cnt_q - wlf_pkg::StepW'(1);
            if (cnt_q == '0) begin
              res_q  <= div_q_n;
              done_q <= 1'b1;
              busy_q <= 1'b0;
            end
          end
          wlf_pkg::UOP_SQRT: begin
            if (sq_ge) acc_q <= acc_q - sq_t;
            qt_q  <= sq_root_n;
            ra_q  <= ra_q >> 2;
            cnt_q <= cnt_q - wlf_pkg::StepW'(1);
            if (cnt_q == '0) begin
              res_q  <= sq_root_n;
              done_q <= 1'b1;
              busy_q <= 1'b0;
            end
          end
          default: begin
            busy_q <= 1'b0;
          end
        endcase
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("unit started while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("done while still busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held more than one cycle");
`endif

endmodule

// ----- rtl/weighted_line_fit_accumulator.sv -----
// Weighted straight-line least-squares accumulator, top level.
// Depends on wlf_pkg and wlf_unit.
//
// Keeps exact weighted running sums (count, sw, swx, swy, swxx, swxy, swyy)
// of points shifted by the origin registers. Each input transfer carries an
// opcode (add, remove, clear, query) and produces exactly one result
// transfer. The block works on one item at a time: in_stall_o is high from
// the accepting edge until the item's result is loaded into the output
// register. Every multiply, divide and square root goes through one shared
// iterative unit (wlf_unit): a multiply takes one cycle per significant bit
// of its second operand's magnitude, a divide steps through every bit of
// its dividend and a square root through every bit pair of its radicand's
// low half. Add and remove run five multiplies; clear and rejected adds or
// removes go straight to the done state without the unit; a full query
// runs six multiplies, up to four divides and two square roots. The finished
// result sits in an output register, so the next item is taken while the
// previous result still waits on out_stall_i. Origin writes are taken
// at any time, but only while idle do they have defined effect on items.
// Slope is Q16.16, intercept Q32.16, both truncated toward zero and
// saturated; errors are floor square roots, saturated. A non-positive
// determinant returns zeros with the degenerate status.
module weighted_line_fit_accumulator (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  input  logic [15:0]        weight_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [10:0]        point_count_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] slope_o,
  output logic signed [47:0] intercept_o,
  output logic [31:0]        slope_error_o,
  output logic [31:0]        intercept_error_o
);

  localparam int W = wlf_pkg::DataW;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ISSUE, ST_WAIT, ST_UPDATE, ST_CHECK, ST_DONE
  } state_e;

  typedef enum logic [4:0] {
    SP_XW, SP_YW, SP_XXW, SP_XYW, SP_YYW,
    SP_SWXX, SP_SXSX, SP_SWXY, SP_SYSX, SP_DSLP,
    SP_SXXSY, SP_SXSXY, SP_DICP, SP_DSERR, SP_RSERR, SP_DIERR, SP_RIERR
  } step_e;

  state_e             state_q;
  step_e              step_q;
  wlf_pkg::opcode_e   op_q;
  wlf_pkg::status_e   status_q, out_status_q;

  logic [15:0]        origin_x_q, origin_y_q;
  logic [wlf_pkg::CountW-1:0] count_q, out_count_q;
  logic [25:0]        sum_w_q;
  logic [43:0]        sum_wx_q, sum_wy_q;
  logic [59:0]        sum_wxx_q, sum_wyy_q;
  logic [60:0]        sum_wxy_q;

  // per-item working registers
  logic [16:0]        xs_q, ys_q;
  logic [15:0]        w_q;
  logic [33:0]        xw_q, yw_q;
  logic [59:0]        xxw_q, yyw_q;
  logic [60:0]        xyw_q;
  logic [W-1:0]       t0_q, d_q, n_q;
  logic               neg_q;
  logic [31:0]        slope_q, serr_q, ierr_q;
  logic [47:0]        icpt_q;

  logic               out_valid_q;
  logic [31:0]        out_slope_q, out_serr_q, out_ierr_q;
  logic [47:0]        out_icpt_q;

  logic               accept;
  logic [16:0]        xs_d, ys_d;
  wlf_pkg::unit_req_t u_req;
  logic [W-1:0]       u_a, u_b, u_res;
  logic               u_done;
  logic [W-1:0]       sw_x, sx_x, sy_x, sxx_x, sxy_x, num_sh, num_mag;
  logic               num_neg;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  assign xs_d = {point_x_i[15], point_x_i} - {origin_x_q[15], origin_x_q};
  assign ys_d = {point_y_i[15], point_y_i} - {origin_y_q[15], origin_y_q};

  // sums widened to the unit's word
  assign sw_x  = {{(W-26){1'b0}}, sum_w_q};
  assign sx_x  = {{(W-44){sum_wx_q[43]}}, sum_wx_q};
  assign sy_x  = {{(W-44){sum_wy_q[43]}}, sum_wy_q};
  assign sxx_x = {{(W-60){sum_wxx_q[59]}}, sum_wxx_q};
  assign sxy_x = {{(W-61){sum_wxy_q[60]}}, sum_wxy_q};

  // numerator scaled to Q.16, divided as a magnitude
  assign num_sh  = {n_q[W-17:0], 16'b0};
  assign num_neg = num_sh[W-1];
  assign num_mag = num_neg ? (~num_sh + W'(1)) : num_sh;

  function automatic logic [31:0] sat32(logic [W-1:0] q, logic neg);
    logic [W-1:0] lim;
    logic [31:0]  m;
    lim = W'(1) << 31;
    if (neg) begin
      m = (q > lim) ? lim[31:0] : q[31:0];
      return ~m + 32'd1;
    end
    m = (q > (lim - W'(1))) ? 32'h7FFF_FFFF : q[31:0];
    return m;
  endfunction

  function automatic logic [47:0] sat48(logic [W-1:0] q, logic neg);
    logic [W-1:0] lim;
    logic [47:0]  m;
    lim = W'(1) << 47;
    if (neg) begin
      m = (q > lim) ? lim[47:0] : q[47:0];
      return ~m + 48'd1;
    end
    m = (q > (lim - W'(1))) ? 48'h7FFF_FFFF_FFFF : q[47:0];
    return m;
  endfunction

  // operand select for the shared unit
  always_comb begin
    u_req.start = (state_q == ST_ISSUE);
    u_req.op    = wlf_pkg::UOP_MUL;
    u_a         = '0;
    u_b         = '0;
    case (step_q)
      SP_XW: begin
        u_a = {{(W-17){xs_q[16]}}, xs_q};
        u_b = {{(W-16){1'b0}}, w_q};
      end
      SP_YW: begin
        u_a = {{(W-17){ys_q[16]}}, ys_q};
        u_b = {{(W-16){1'b0}}, w_q};
      end
      SP_XXW: begin
        u_a = {{(W-34){xw_q[33]}}, xw_q};
        u_b = {{(W-17){xs_q[16]}}, xs_q};
      end
      SP_XYW: begin
        u_a = {{(W-34){xw_q[33]}}, xw_q};
        u_b = {{(W-17){ys_q[16]}}, ys_q};
      end
      SP_YYW: begin
        u_a = {{(W-34){yw_q[33]}}, yw_q};
        u_b = {{(W-17){ys_q[16]}}, ys_q};
      end
      SP_SWXX: begin
        u_a = sw_x;
        u_b = sxx_x;
      end
      SP_SXSX: begin
        u_a = sx_x;
        u_b = sx_x;
      end
      SP_SWXY: begin
        u_a = sw_x;
        u_b = sxy_x;
      end
      SP_SYSX: begin
        u_a = sy_x;
        u_b = sx_x;
      end
      SP_SXXSY: begin
        u_a = sxx_x;
        u_b = sy_x;
      end
      SP_SXSXY: begin
        u_a = sx_x;
        u_b = sxy_x;
      end
      SP_DSLP, SP_DICP: begin
        u_req.op = wlf_pkg::UOP_DIV;
        u_a      = num_mag;
        u_b      = d_q;
      end
      SP_DSERR: begin
        u_req.op = wlf_pkg::UOP_DIV;
        u_a      = {{(W-66){1'b0}}, sum_w_q, 40'b0};
        u_b      = d_q;
      end
      SP_DIERR: begin
        u_req.op = wlf_pkg::UOP_DIV;
        u_a      = {{(W-100){sum_wxx_q[59]}}, sum_wxx_q, 40'b0};
        u_b      = d_q;
      end
      SP_RSERR, SP_RIERR: begin
        u_req.op = wlf_pkg::UOP_SQRT;
        u_a      = t0_q;
      end
      default: begin
        u_req.op = wlf_pkg::UOP_MUL;
      end
    endcase
  end

  wlf_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (u_req),
    .a_i    (u_a),
    .b_i    (u_b),
    .done_o (u_done),
    .res_o  (u_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= SP_XW;
      op_q         <= wlf_pkg::OP_ADD;
      status_q     <= wlf_pkg::STS_OK;
      out_status_q <= wlf_pkg::STS_OK;
      origin_x_q   <= '0;
      origin_y_q   <= '0;
      count_q      <= '0;
      out_count_q  <= '0;
      sum_w_q      <= '0;
      sum_wx_q     <= '0;
      sum_wy_q     <= '0;
      sum_wxx_q    <= '0;
      sum_wxy_q    <= '0;
      sum_wyy_q    <= '0;
      xs_q         <= '0;
      ys_q         <= '0;
      w_q          <= '0;
      xw_q         <= '0;
      yw_q         <= '0;
      xxw_q        <= '0;
      xyw_q        <= '0;
      yyw_q        <= '0;
      t0_q         <= '0;
      d_q          <= '0;
      n_q          <= '0;
      neg_q        <= 1'b0;
      slope_q      <= '0;
      icpt_q       <= '0;
      serr_q       <= '0;
      ierr_q       <= '0;
      out_valid_q  <= 1'b0;
      out_slope_q  <= '0;
      out_icpt_q   <= '0;
      out_serr_q   <= '0;
      out_ierr_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i) origin_y_q <= cfg_data_i;
        else           origin_x_q <= cfg_data_i;
      end

      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q     <= wlf_pkg::opcode_e'(opcode_i);
            xs_q     <= xs_d;
            ys_q     <= ys_d;
            w_q      <= weight_i;
            status_q <= wlf_pkg::STS_OK;
            slope_q  <= '0;
            icpt_q   <= '0;
            serr_q   <= '0;
            ierr_q   <= '0;
            case (wlf_pkg::opcode_e'(opcode_i))
              wlf_pkg::OP_ADD: begin
                if (count_q >= wlf_pkg::CountW'(wlf_pkg::MaxPoints)) begin
                  status_q <= wlf_pkg::STS_FULL;
                  state_q  <= ST_DONE;
                end else begin
                  step_q  <= SP_XW;
                  state_q <= ST_ISSUE;
                end
              end
              wlf_pkg::OP_REM: begin
                if (count_q == '0) begin
                  status_q <= wlf_pkg::STS_EMPTY;
                  state_q  <= ST_DONE;
                end else begin
                  step_q  <= SP_XW;
                  state_q <= ST_ISSUE;
                end
              end
              wlf_pkg::OP_CLEAR: begin
                count_q   <= '0;
                sum_w_q   <= '0;
                sum_wx_q  <= '0;
                sum_wy_q  <= '0;
                sum_wxx_q <= '0;
                sum_wxy_q <= '0;
                sum_wyy_q <= '0;
                state_q   <= ST_DONE;
              end
              default: begin
                step_q  <= SP_SWXX;
                state_q <= ST_ISSUE;
              end
            endcase
          end
        end

        ST_ISSUE: begin
          neg_q   <= num_neg;
          state_q <= ST_WAIT;
        end

        ST_WAIT: begin
          if (u_done) begin
            state_q <= ST_ISSUE;
            case (step_q)
              SP_XW:  begin xw_q  <= u_res[33:0]; step_q <= SP_YW;  end
              SP_YW:  begin yw_q  <= u_res[33:0]; step_q <= SP_XXW; end
              SP_XXW: begin xxw_q <= u_res[59:0]; step_q <= SP_XYW; end
              SP_XYW: begin xyw_q <= u_res[60:0]; step_q <= SP_YYW; end
              SP_YYW: begin
                yyw_q   <= u_res[59:0];
                state_q <= ST_UPDATE;
              end
              SP_SWXX: begin t0_q <= u_res; step_q <= SP_SXSX; end
              SP_SXSX: begin
                d_q     <= t0_q - u_res;
                state_q <= ST_CHECK;
              end
              SP_SWXY: begin t0_q <= u_res;        step_q <= SP_SYSX;  end
              SP_SYSX: begin n_q  <= t0_q - u_res; step_q <= SP_DSLP;  end
              SP_DSLP: begin
                slope_q <= sat32(u_res, neg_q);
                step_q  <= SP_SXXSY;
              end
              SP_SXXSY: begin t0_q <= u_res;        step_q <= SP_SXSXY; end
              SP_SXSXY: begin n_q  <= t0_q - u_res; step_q <= SP_DICP;  end
              SP_DICP: begin
                icpt_q <= sat48(u_res, neg_q);
                if (count_q > wlf_pkg::CountW'(2)) step_q  <= SP_DSERR;
                else                               state_q <= ST_DONE;
              end
              SP_DSERR: begin
                // quotient above 64 bits: root is past the Q12.20 range
                if (u_res[W-1:W/2] != '0) begin
                  serr_q <= '1;
                  step_q <= SP_DIERR;
                end else begin
                  t0_q   <= u_res;
                  step_q <= SP_RSERR;
                end
              end
              SP_RSERR: begin serr_q <= u_res[31:0]; step_q <= SP_DIERR; end
              SP_DIERR: begin
                if (u_res[W-1:W/2] != '0) begin
                  ierr_q  <= '1;
                  state_q <= ST_DONE;
                end else begin
                  t0_q   <= u_res;
                  step_q <= SP_RIERR;
                end
              end
              SP_RIERR: begin
                ierr_q  <= u_res[31:0];
                state_q <= ST_DONE;
              end
              default: begin
                state_q <= ST_DONE;
              end
            endcase
          end
        end

        ST_CHECK: begin
          // determinant must be strictly positive
          if (d_q[W-1] || (d_q == '0)) begin
            status_q <= wlf_pkg::STS_DEGEN;
            state_q  <= ST_DONE;
          end else begin
            step_q  <= (count_q > wlf_pkg::CountW'(1)) ? SP_SWXY : SP_SXXSY;
            state_q <= ST_ISSUE;
          end
        end

        ST_UPDATE: begin
          if (op_q == wlf_pkg::OP_ADD) begin
            count_q   <= count_q + wlf_pkg::CountW'(1);
            sum_w_q   <= sum_w_q + {10'b0, w_q};
            sum_wx_q  <= sum_wx_q + {{10{xw_q[33]}}, xw_q};
            sum_wy_q  <= sum_wy_q + {{10{yw_q[33]}}, yw_q};
            sum_wxx_q <= sum_wxx_q + xxw_q;
            sum_wxy_q <= sum_wxy_q + xyw_q;
            sum_wyy_q <= sum_wyy_q + yyw_q;
          end else begin
            count_q   <= count_q - wlf_pkg::CountW'(1);
            sum_w_q   <= sum_w_q - {10'b0, w_q};
            sum_wx_q  <= sum_wx_q - {{10{xw_q[33]}}, xw_q};
            sum_wy_q  <= sum_wy_q - {{10{yw_q[33]}}, yw_q};
            sum_wxx_q <= sum_wxx_q - xxw_q;
            sum_wxy_q <= sum_wxy_q - xyw_q;
            sum_wyy_q <= sum_wyy_q - yyw_q;
          end
          state_q <= ST_DONE;
        end

        ST_DONE: begin
          // load the output register once the previous result is gone
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_count_q  <= count_q;
            out_status_q <= status_q;
            out_slope_q  <= slope_q;
            out_icpt_q   <= icpt_q;
            out_serr_q   <= serr_q;
            out_ierr_q   <= ierr_q;
            state_q      <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign point_count_o     = out_count_q;
  assign status_o          = out_status_q;
  assign slope_o           = out_slope_q;
  assign intercept_o       = out_icpt_q;
  assign slope_error_o     = out_serr_q;
  assign intercept_error_o = out_ierr_q;

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= wlf_pkg::CountW'(wlf_pkg::MaxPoints)) else $error("count above max");
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_status_q == wlf_pkg::STS_DEGEN)) |->
      (slope_o == '0 && intercept_o == '0 && slope_error_o == '0 &&
       intercept_error_o == '0)) else $error("degenerate fit with nonzero fields");
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_done |-> (state_q == ST_WAIT)) else $error("unit result outside wait");
`endif

endmodule

// ----- tb/wlf_checker.sv -----
// Scoreboard for the weighted line-fit accumulator: watches both channels and the
// origin writes, predicts each result and compares it field by field.
// Depends on wlf_pkg.
module wlf_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] point_x_i,
  input  logic [15:0] point_y_i,
  input  logic [15:0] weight_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [10:0] point_count_i,
  input  logic [1:0]  status_i,
  input  logic [31:0] slope_i,
  input  logic [47:0] intercept_i,
  input  logic [31:0] slope_error_i,
  input  logic [31:0] intercept_error_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [10:0] cnt;
    logic [1:0]  sts;
    logic [31:0] slope;
    logic [47:0] icpt;
    logic [31:0] serr;
    logic [31:0] ierr;
  } fit_res_t;

  fit_res_t fit_q[$];

  logic [15:0] org_x, org_y;
  logic [10:0] n_pts;
  logic [25:0] s_w;
  logic [43:0] s_wx, s_wy;
  logic [59:0] s_wxx, s_wyy;
  logic [60:0] s_wxy;

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // truncate toward zero, then clamp to a signed field of the given width
  function automatic logic [63:0] div_sat(input logic signed [127:0] num,
                                          input logic [127:0] den, input int bits);
    logic [127:0] mag, q;
    logic [63:0] lim, m;
    mag = num[127] ? -num : num;
    q = mag / den;
    lim = 64'd1 << (bits - 1);
    if (num[127]) begin
      m = (q > {64'd0, lim}) ? lim : q[63:0];
      return (-m) & ((64'd1 << bits) - 1);
    end
    m = (q > {64'd0, lim - 64'd1}) ? lim - 64'd1 : q[63:0];
    return m & ((64'd1 << bits) - 1);
  endfunction

  // floor(sqrt(num * 2^40 / den)), clamped to 32 bits
  function automatic logic [31:0] err_sqrt(input logic signed [127:0] num,
                                           input logic [127:0] den);
    logic [127:0] q;
    logic [63:0] s;
    q = (num <<< 40) / den;
    if (q[127:64] != 0) return 32'hFFFF_FFFF;
    s = isqrt(q[63:0]);
    return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic fit_res_t fit_step(input logic [1:0] op, input logic [15:0] px,
                                        input logic [15:0] py, input logic [15:0] pw);
    fit_res_t r;
    longint x, y, w;
    logic signed [127:0] sw, sx, sy, sxx, sxy, d, nm;
    r = '0;
    x = longint'($signed(px)) - longint'($signed(org_x));
    y = longint'($signed(py)) - longint'($signed(org_y));
    w = longint'(pw);
    case (op)
      wlf_pkg::OP_ADD, wlf_pkg::OP_REM: begin
        if (op == wlf_pkg::OP_ADD && n_pts >= wlf_pkg::MaxPoints) begin
          r.sts = wlf_pkg::STS_FULL;
        end else if (op == wlf_pkg::OP_REM && n_pts == 0) begin
          r.sts = wlf_pkg::STS_EMPTY;
        end else if (op == wlf_pkg::OP_ADD) begin
          n_pts = n_pts + 1;
          s_w   = s_w + 26'(w);
          s_wx  = s_wx + 44'(x * w);
          s_wy  = s_wy + 44'(y * w);
          s_wxx = s_wxx + 60'(x * x * w);
          s_wxy = s_wxy + 61'(x * y * w);
          s_wyy = s_wyy + 60'(y * y * w);
        end else begin
          n_pts = n_pts - 1;
          s_w   = s_w - 26'(w);
          s_wx  = s_wx - 44'(x * w);
          s_wy  = s_wy - 44'(y * w);
          s_wxx = s_wxx - 60'(x * x * w);
          s_wxy = s_wxy - 61'(x * y * w);
          s_wyy = s_wyy - 60'(y * y * w);
        end
      end
      wlf_pkg::OP_CLEAR: begin
        n_pts = 0; s_w = 0; s_wx = 0; s_wy = 0; s_wxx = 0; s_wxy = 0; s_wyy = 0;
      end
      default: begin
        sw  = {102'd0, s_w};
        sx  = $signed(s_wx);
        sy  = $signed(s_wy);
        sxx = $signed(s_wxx);
        sxy = $signed(s_wxy);
        d = sw * sxx - sx * sx;
        if (d[127] || d == 0) begin
          r.sts = wlf_pkg::STS_DEGEN;
        end else begin
          if (n_pts > 1) begin
            nm = sw * sxy - sy * sx;
            r.slope = 32'(div_sat(nm <<< 16, d, 32));
          end
          nm = sxx * sy - sx * sxy;
          r.icpt = 48'(div_sat(nm <<< 16, d, 48));
          if (n_pts > 2) begin
            r.serr = err_sqrt(sw, d);
            r.ierr = err_sqrt(sxx, d);
          end
        end
      end
    endcase
    r.cnt = n_pts;
    return r;
  endfunction

  assign pending_o = fit_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    fit_res_t e;
    if (!rst_ni) begin
      org_x = 0; org_y = 0;
      n_pts = 0; s_w = 0; s_wx = 0; s_wy = 0; s_wxx = 0; s_wxy = 0; s_wyy = 0;
      fit_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i) org_y = cfg_data_i;
        else org_x = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (fit_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected (count %0d)", $time,
                   point_count_i);
          fail_count_o++;
        end else begin
          e = fit_q.pop_front();
          if (e !== {point_count_i, status_i, slope_i, intercept_i, slope_error_i,
                     intercept_error_i}) begin
            $display("%0t: mismatch exp cnt=%0d sts=%0d slope=%h icpt=%h se=%h ie=%h",
                     $time, e.cnt, e.sts, e.slope, e.icpt, e.serr, e.ierr);
            $display("%0t:          act cnt=%0d sts=%0d slope=%h icpt=%h se=%h ie=%h",
                     $time, point_count_i, status_i, slope_i, intercept_i,
                     slope_error_i, intercept_error_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        fit_q.push_back(fit_step(opcode_i, point_x_i, point_y_i, weight_i));
    end
  end

endmodule

// ----- tb/tb_weighted_line_fit_accumulator.sv -----
// Top of the weighted line-fit accumulator testbench: clock, reset, stimulus,
// receiver stalls and the verdict. Depends on wlf_pkg, the block and wlf_checker.
module tb_weighted_line_fit_accumulator;

  localparam int HoldCycles = 3000;
  localparam int WatchLimit = 20000;

  logic        clk_i, rst_ni;
  logic        cfg_we_i, cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i, in_stall_o;
  logic [1:0]  opcode_i;
  logic [15:0] point_x_i, point_y_i, weight_i;
  logic        out_valid_o, out_stall_i;
  logic [10:0] point_count_o;
  logic [1:0]  status_o;
  logic [31:0] slope_o, slope_error_o, intercept_error_o;
  logic [47:0] intercept_o;
  int          fail_count, pending;

  // idle mode: 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly
  int          idle_mode;
  bit          hold_req;
  bit          in_xfer, any_xfer;
  int          quiet_cycles;

  // recent points kept so that removes usually undo a real add
  logic [15:0] keep_x[16], keep_y[16], keep_w[16];
  int          keep_n;

  weighted_line_fit_accumulator u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .opcode_i, .point_x_i, .point_y_i, .weight_i,
    .out_valid_o, .out_stall_i, .point_count_o, .status_o, .slope_o,
    .intercept_o, .slope_error_o, .intercept_error_o
  );

  wlf_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .opcode_i, .point_x_i, .point_y_i,
    .weight_i, .out_valid_i(out_valid_o), .out_stall_i, .point_count_i(point_count_o),
    .status_i(status_o), .slope_i(slope_o), .intercept_i(intercept_o),
    .slope_error_i(slope_error_o), .intercept_error_i(intercept_error_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // transfer flags seen at the rising edge, read by the stimulus at the falling one
  always @(posedge clk_i) begin
    in_xfer  <= in_valid_i && !in_stall_o;
    any_xfer <= (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i);
  end

  // watchdog: cycles with no transfer on either channel
  always @(negedge clk_i) begin
    if (!rst_ni || any_xfer) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stalls per idle mode, plus one long hold-off on request
  initial begin
    int hold_left;
    out_stall_i = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req && hold_left == 0) hold_left = HoldCycles;
      if (hold_left > 0) begin
        out_stall_i = 1;
        hold_left--;
      end else if (idle_mode == 2) out_stall_i = ($urandom_range(99) < 51);
      else if (idle_mode == 3) out_stall_i = ($urandom_range(99) < 7);
      else out_stall_i = 0;
    end
  end

  task automatic send(input wlf_pkg::opcode_e op, input logic [15:0] x,
                      input logic [15:0] y, input logic [15:0] w);
    int pct;
    pct = (idle_mode == 1) ? 51 : (idle_mode == 3) ? 7 : 0;
    while ($urandom_range(99) < pct) begin
      in_valid_i = 0;
      @(negedge clk_i);
    end
    in_valid_i = 1;
    opcode_i = op;
    point_x_i = x;
    point_y_i = y;
    weight_i = w;
    do @(negedge clk_i); while (!in_xfer);
    if (op == wlf_pkg::OP_ADD) begin
      keep_x[keep_n % 16] = x;
      keep_y[keep_n % 16] = y;
      keep_w[keep_n % 16] = w;
      keep_n++;
    end
  endtask

  // origin writes only once every result is back
  task automatic set_origin(input logic [15:0] ox, input logic [15:0] oy);
    in_valid_i = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_we_i = 1; cfg_idx_i = 0; cfg_data_i = ox;
    @(negedge clk_i);
    cfg_idx_i = 1; cfg_data_i = oy;
    @(negedge clk_i);
    cfg_we_i = 0;
  endtask

  function automatic logic [15:0] rnd_coord();
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return 16'($signed($urandom_range(200)) - 100);
      2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed($urandom_range(4000)) - 2000);
    endcase
  endfunction

  function automatic logic [15:0] rnd_weight();
    case ($urandom_range(4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0100;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic random_items(input int n);
    int k, sel, j;
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      if (sel < 45) send(wlf_pkg::OP_ADD, rnd_coord(), rnd_coord(), rnd_weight());
      else if (sel < 55 && keep_n > 0) begin
        j = $urandom_range(((keep_n < 16) ? keep_n : 16) - 1);
        send(wlf_pkg::OP_REM, keep_x[j], keep_y[j], keep_w[j]);
      end else if (sel < 62) send(wlf_pkg::OP_REM, rnd_coord(), rnd_coord(), rnd_weight());
      else if (sel < 66) send(wlf_pkg::OP_CLEAR, rnd_coord(), rnd_coord(), rnd_weight());
      else send(wlf_pkg::OP_QUERY, rnd_coord(), rnd_coord(), rnd_weight());
    end
  endtask

  initial begin
    int k;
    rst_ni = 0;
    cfg_we_i = 0; cfg_idx_i = 0; cfg_data_i = 0;
    in_valid_i = 0; opcode_i = wlf_pkg::OP_ADD;
    point_x_i = 0; point_y_i = 0; weight_i = 0;
    idle_mode = 0; hold_req = 0; keep_n = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: empty fits, remove when empty, extremes, degenerate line
    send(wlf_pkg::OP_QUERY, 0, 0, 0);
    send(wlf_pkg::OP_REM, 16'h1234, 16'h4321, 16'h0100);
    send(wlf_pkg::OP_ADD, 16'h7FFF, 16'h8000, 16'hFFFF);
    send(wlf_pkg::OP_QUERY, 0, 0, 0);
    send(wlf_pkg::OP_ADD, 16'h8000, 16'h7FFF, 16'hFFFF);
    send(wlf_pkg::OP_QUERY, 0, 0, 0);
    send(wlf_pkg::OP_ADD, 16'h0000, 16'h0000, 16'h0001);
    send(wlf_pkg::OP_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(wlf_pkg::OP_REM, 16'h0000, 16'h0000, 16'h0001);
    send(wlf_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // all points on one x: zero determinant
    send(wlf_pkg::OP_ADD, 16'd5, 16'd1, 16'h0100);
    send(wlf_pkg::OP_ADD, 16'd5, 16'd9, 16'h0200);
    send(wlf_pkg::OP_ADD, 16'd5, 16'd3, 16'h0100);
    send(wlf_pkg::OP_QUERY, 0, 0, 0);
    // zero-weight points only
    send(wlf_pkg::OP_CLEAR, 0, 0, 0);
    send(wlf_pkg::OP_ADD, 16'd1, 16'd2, 16'h0000);
    send(wlf_pkg::OP_ADD, 16'd3, 16'd4, 16'h0000);
    send(wlf_pkg::OP_QUERY, 0, 0, 0);
    // remove of a point never added, sums wrap
    send(wlf_pkg::OP_REM, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    send(wlf_pkg::OP_QUERY, 0, 0, 0);

    // origin extremes, clear keeps the origin
    set_origin(16'h8000, 16'h7FFF);
    send(wlf_pkg::OP_CLEAR, 0, 0, 0);
    send(wlf_pkg::OP_ADD, 16'h7FFF, 16'h8000, 16'h0100);
    send(wlf_pkg::OP_ADD, 16'h8000, 16'h7FFF, 16'h0180);
    send(wlf_pkg::OP_ADD, 16'h0000, 16'h0000, 16'h0040);
    send(wlf_pkg::OP_QUERY, 0, 0, 0);

    // random phases, one per idle mode, each with its own origin;
    // the first also holds the receiver off so the block backs up
    set_origin(16'h7FFF, 16'h8000);
    idle_mode = 0;
    hold_req = 1;
    repeat (2) @(negedge clk_i);
    hold_req = 0;
    for (k = 0; k < 20; k++) send(wlf_pkg::OP_CLEAR, 0, 0, 0);
    random_items(150);
    set_origin(16'($urandom_range(65535)), 16'($urandom_range(65535)));
    idle_mode = 1;
    random_items(160);
    set_origin(16'hFFFF, 16'h0001);
    idle_mode = 2;
    random_items(160);
    set_origin(16'($urandom_range(65535)), 16'($urandom_range(65535)));
    idle_mode = 3;
    random_items(160);

    in_valid_i = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/wlf_pkg.sv
rtl/wlf_unit.sv
rtl/weighted_line_fit_accumulator.sv
tb/wlf_checker.sv
tb/tb_weighted_line_fit_accumulator.sv
